[design/assert_macros.svh]
// Assertion helpers; defining ASSERT_OFF leaves every use empty.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs)
`define ASSERT_NEXT(label, clk, rst, lhs, rhs)

`endif

`endif

[design/dtr_pkg.sv]
package dtr_pkg;

   localparam int SLOT_W      = 7;
   localparam int HANDLE_W    = 32;
   localparam int RIGHTS_W    = 64;
   localparam int ADDR_LIMIT  = 128;
   localparam int GROUP_SLOTS = 16;
   localparam int GSEL_W      = 4;

   typedef enum logic [1:0] {
      REQ_ADD    = 2'd0,
      REQ_LOOKUP = 2'd1,
      REQ_CLOSE  = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_BADDESC  = 2'd1,
      STS_NORIGHTS = 2'd2,
      STS_FULL     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      STATE_IDLE = 2'b01,
      STATE_EXEC = 2'b10
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [RIGHTS_W-1:0] base;
      logic [RIGHTS_W-1:0] inherit;
   } entry_type;

endpackage

[design/dtr_ctrl.sv]
module dtr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output dtr_pkg::cmd_type cmd
);

   dtr_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         dtr_pkg::STATE_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = dtr_pkg::STATE_EXEC;
            end
         end
         dtr_pkg::STATE_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = dtr_pkg::STATE_IDLE;
         end
         default: begin
            state_in = dtr_pkg::STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dtr_pkg::STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != dtr_pkg::STATE_IDLE);

endmodule

[design/dtr_dpath.sv]
module dtr_dpath #(
   parameter int TABLE_SLOTS = 128
) (
   input  logic                             clock,
   input  logic                             reset,
   input  dtr_pkg::cmd_type                 cmd,
   input  logic [1:0]                       req_type,
   input  logic [dtr_pkg::SLOT_W-1:0]       req_slot_num,
   input  logic [dtr_pkg::HANDLE_W-1:0]     req_object_handle,
   input  logic [dtr_pkg::RIGHTS_W-1:0]     req_base_rights,
   input  logic [dtr_pkg::RIGHTS_W-1:0]     req_inherit_rights,
   input  logic [dtr_pkg::RIGHTS_W-1:0]     req_required_rights,
   output logic                             rsp_strobe,
   output logic [1:0]                       rsp_status,
   output logic [dtr_pkg::SLOT_W-1:0]       rsp_slot_out,
   output logic [dtr_pkg::HANDLE_W-1:0]     rsp_handle_out,
   output logic [dtr_pkg::RIGHTS_W-1:0]     rsp_base_rights_out,
   output logic [dtr_pkg::RIGHTS_W-1:0]     rsp_inherit_rights_out
);

   localparam int USABLE    = (TABLE_SLOTS < dtr_pkg::ADDR_LIMIT) ?
                              TABLE_SLOTS : dtr_pkg::ADDR_LIMIT;
   localparam int ADDR_W    = (USABLE > 1) ? $clog2(USABLE) : 1;
   localparam int MEM_DEPTH = 1 << ADDR_W;
   localparam int NGROUPS   = (USABLE + dtr_pkg::GROUP_SLOTS - 1) / dtr_pkg::GROUP_SLOTS;
   localparam int GIDX_W    = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
   localparam int PAD_W     = NGROUPS * dtr_pkg::GROUP_SLOTS;

   // request held for the execute cycle
   logic [1:0]                   type_ff;
   logic [dtr_pkg::SLOT_W-1:0]   slot_ff;
   dtr_pkg::entry_type           wr_entry_ff;
   logic [dtr_pkg::RIGHTS_W-1:0] need_ff;

   logic [USABLE-1:0]    valid_ff, valid_in;
   logic [PAD_W-1:0]     occ_pad;
   logic [MEM_DEPTH-1:0] vld_pad;

   logic [NGROUPS-1:0]        grp_free_ff, grp_free_in;
   logic [dtr_pkg::GSEL_W-1:0] grp_idx_ff [NGROUPS];
   logic [dtr_pkg::GSEL_W-1:0] grp_idx_in [NGROUPS];

   dtr_pkg::entry_type mem [MEM_DEPTH];
   dtr_pkg::entry_type rd_ff;

   logic [GIDX_W-1:0]                sel_grp;
   logic [dtr_pkg::GSEL_W-1:0]       sel_idx;
   logic [GIDX_W+dtr_pkg::GSEL_W-1:0] alloc_wide;
   logic [ADDR_W-1:0]                alloc_addr;
   logic [ADDR_W-1:0]                slot_addr;
   logic                             any_free;
   logic                             in_range;
   logic                             slot_ok;
   logic                             add_ok;

   logic                             rsp_strobe_ff;
   logic [1:0]                       status_ff, status_in;
   logic [dtr_pkg::SLOT_W-1:0]       slot_out_ff, slot_out_in;
   dtr_pkg::entry_type               rsp_entry_ff, rsp_entry_in;

   // padding above the usable range counts as occupied for the search
   // and as free for lookups
   for (genvar i = 0; i < PAD_W; i++) begin : g_occ
      if (i < USABLE) begin : g_used
         assign occ_pad[i] = valid_ff[i];
      end else begin : g_pad
         assign occ_pad[i] = 1'b1;
      end
   end

   for (genvar i = 0; i < MEM_DEPTH; i++) begin : g_vld
      if (i < USABLE) begin : g_used
         assign vld_pad[i] = valid_ff[i];
      end else begin : g_pad
         assign vld_pad[i] = 1'b0;
      end
   end

   // first level of the free-slot search, registered every cycle
   always_comb begin
      for (int g = 0; g < NGROUPS; g++) begin
         grp_free_in[g] = 1'b0;
         grp_idx_in[g]  = '0;
         for (int b = dtr_pkg::GROUP_SLOTS - 1; b >= 0; b--) begin
            if (!occ_pad[g*dtr_pkg::GROUP_SLOTS + b]) begin
               grp_free_in[g] = 1'b1;
               grp_idx_in[g]  = dtr_pkg::GSEL_W'(b);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_free_ff <= grp_free_in;
      for (int g = 0; g < NGROUPS; g++) begin
         grp_idx_ff[g] <= grp_idx_in[g];
      end
   end

   // second level: lowest group with a free slot
   always_comb begin
      sel_grp = '0;
      sel_idx = '0;
      for (int g = NGROUPS - 1; g >= 0; g--) begin
         if (grp_free_ff[g]) begin
            sel_grp = GIDX_W'(g);
            sel_idx = grp_idx_ff[g];
         end
      end
   end

   assign any_free   = |grp_free_ff;
   assign alloc_wide = {sel_grp, sel_idx};
   assign alloc_addr = alloc_wide[ADDR_W-1:0];
   assign slot_addr  = slot_ff[ADDR_W-1:0];
   assign in_range   = (8'(slot_ff) < 8'(USABLE));
   assign slot_ok    = in_range && vld_pad[slot_addr];
   assign add_ok     = (type_ff == dtr_pkg::REQ_ADD) && any_free;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff             <= req_type;
         slot_ff             <= req_slot_num;
         wr_entry_ff.handle  <= req_object_handle;
         wr_entry_ff.base    <= req_base_rights;
         wr_entry_ff.inherit <= req_inherit_rights;
         need_ff             <= req_required_rights;
      end
   end

   // entry store: written on add, read at capture for a lookup
   always_ff @(posedge clock) begin
      if (cmd.execute && add_ok) begin
         mem[alloc_addr] <= wr_entry_ff;
      end
      if (cmd.capture) begin
         rd_ff <= mem[req_slot_num[ADDR_W-1:0]];
      end
   end

   always_comb begin
      valid_in     = valid_ff;
      status_in    = dtr_pkg::STS_BADDESC;
      slot_out_in  = slot_ff;
      rsp_entry_in = '0;
      case (type_ff)
         dtr_pkg::REQ_ADD: begin
            if (any_free) begin
               valid_in[alloc_addr] = 1'b1;
               status_in            = dtr_pkg::STS_OK;
               slot_out_in          = dtr_pkg::SLOT_W'(alloc_addr);
            end else begin
               status_in   = dtr_pkg::STS_FULL;
               slot_out_in = '0;
            end
         end
         dtr_pkg::REQ_LOOKUP: begin
            if (slot_ok) begin
               if ((rd_ff.base & need_ff) != need_ff) begin
                  status_in = dtr_pkg::STS_NORIGHTS;
               end else begin
                  status_in    = dtr_pkg::STS_OK;
                  rsp_entry_in = rd_ff;
               end
            end
         end
         dtr_pkg::REQ_CLOSE: begin
            if (slot_ok) begin
               valid_in[slot_addr] = 1'b0;
               status_in           = dtr_pkg::STS_OK;
            end
         end
         default: begin
            status_in = dtr_pkg::STS_BADDESC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.execute;
         if (cmd.execute) begin
            valid_ff <= valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff    <= status_in;
         slot_out_ff  <= slot_out_in;
         rsp_entry_ff <= rsp_entry_in;
      end
   end

   assign rsp_strobe             = rsp_strobe_ff;
   assign rsp_status             = status_ff;
   assign rsp_slot_out           = slot_out_ff;
   assign rsp_handle_out         = rsp_entry_ff.handle;
   assign rsp_base_rights_out    = rsp_entry_ff.base;
   assign rsp_inherit_rights_out = rsp_entry_ff.inherit;

endmodule

[design/descriptor_table_with_rights.sv]
// A request transferred on start is captured, then executed; its result shows
// for one cycle on the registered response outputs, with rsp_strobe high.
// Busy is high while a request executes, so the capture/execute sequencer takes
// the next one only once it is idle again; the free-slot search has two levels.
// Reset (synchronous): all slots free, sequencer idle, no result pending.
`include "assert_macros.svh"

module descriptor_table_with_rights #(
   parameter int TABLE_SLOTS = 128
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_type,
   input  logic [dtr_pkg::SLOT_W-1:0]   req_slot_num,
   input  logic [dtr_pkg::HANDLE_W-1:0] req_object_handle,
   input  logic [dtr_pkg::RIGHTS_W-1:0] req_base_rights,
   input  logic [dtr_pkg::RIGHTS_W-1:0] req_inherit_rights,
   input  logic [dtr_pkg::RIGHTS_W-1:0] req_required_rights,
   output logic                         rsp_strobe,
   output logic [1:0]                   rsp_status,
   output logic [dtr_pkg::SLOT_W-1:0]   rsp_slot_out,
   output logic [dtr_pkg::HANDLE_W-1:0] rsp_handle_out,
   output logic [dtr_pkg::RIGHTS_W-1:0] rsp_base_rights_out,
   output logic [dtr_pkg::RIGHTS_W-1:0] rsp_inherit_rights_out
);

   dtr_pkg::cmd_type cmd;

   dtr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   dtr_dpath #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_dpath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .req_type               (req_type),
      .req_slot_num           (req_slot_num),
      .req_object_handle      (req_object_handle),
      .req_base_rights        (req_base_rights),
      .req_inherit_rights     (req_inherit_rights),
      .req_required_rights    (req_required_rights),
      .rsp_strobe             (rsp_strobe),
      .rsp_status             (rsp_status),
      .rsp_slot_out           (rsp_slot_out),
      .rsp_handle_out         (rsp_handle_out),
      .rsp_base_rights_out    (rsp_base_rights_out),
      .rsp_inherit_rights_out (rsp_inherit_rights_out)
   );

   // every transfer yields exactly one result, after the execute state
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy && !rsp_strobe)
   `ASSERT_NEXT(a_exec_result, clock, reset, busy, rsp_strobe && !busy)
   `ASSERT_IMPLIES(a_strobe_idle, clock, reset, rsp_strobe, !busy)
   `ASSERT_IMPLIES(a_full_slot, clock, reset,
      rsp_strobe && (rsp_status == dtr_pkg::STS_FULL), rsp_slot_out == '0)

endmodule

[tb/sv/tb_descriptor_table_with_rights.sv]
`timescale 1ns / 1ps

module tb_descriptor_table_with_rights;

   localparam int SLOTS        = 128;
   localparam int RANDOM_ITEMS = 550;
   localparam int CALM_TAIL    = 80;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int REPORT_MAX   = 10;

   // code 3 is not decoded by the block; it must answer bad descriptor
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]                   kind;
      logic [dtr_pkg::SLOT_W-1:0]   slot;
      logic [dtr_pkg::HANDLE_W-1:0] handle;
      logic [dtr_pkg::RIGHTS_W-1:0] base;
      logic [dtr_pkg::RIGHTS_W-1:0] inherit;
      logic [dtr_pkg::RIGHTS_W-1:0] need;
   } desc_req_type;

   typedef struct packed {
      logic [1:0]                   status;
      logic [dtr_pkg::SLOT_W-1:0]   slot;
      logic [dtr_pkg::HANDLE_W-1:0] handle;
      logic [dtr_pkg::RIGHTS_W-1:0] base;
      logic [dtr_pkg::RIGHTS_W-1:0] inherit;
   } desc_rsp_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [1:0]                   req_type = dtr_pkg::REQ_ADD;
   logic [dtr_pkg::SLOT_W-1:0]   req_slot_num = '0;
   logic [dtr_pkg::HANDLE_W-1:0] req_object_handle = '0;
   logic [dtr_pkg::RIGHTS_W-1:0] req_base_rights = '0;
   logic [dtr_pkg::RIGHTS_W-1:0] req_inherit_rights = '0;
   logic [dtr_pkg::RIGHTS_W-1:0] req_required_rights = '0;
   logic                         rsp_strobe;
   logic [1:0]                   rsp_status;
   logic [dtr_pkg::SLOT_W-1:0]   rsp_slot_out;
   logic [dtr_pkg::HANDLE_W-1:0] rsp_handle_out;
   logic [dtr_pkg::RIGHTS_W-1:0] rsp_base_rights_out;
   logic [dtr_pkg::RIGHTS_W-1:0] rsp_inherit_rights_out;

   descriptor_table_with_rights u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_type               (req_type),
      .req_slot_num           (req_slot_num),
      .req_object_handle      (req_object_handle),
      .req_base_rights        (req_base_rights),
      .req_inherit_rights     (req_inherit_rights),
      .req_required_rights    (req_required_rights),
      .rsp_strobe             (rsp_strobe),
      .rsp_status             (rsp_status),
      .rsp_slot_out           (rsp_slot_out),
      .rsp_handle_out         (rsp_handle_out),
      .rsp_base_rights_out    (rsp_base_rights_out),
      .rsp_inherit_rights_out (rsp_inherit_rights_out)
   );

   always #5 clock = ~clock;

   desc_req_type request_backlog[$];
   desc_rsp_type outstanding_replies[$];

   // predicted table contents
   logic                         slot_live [SLOTS];
   logic [dtr_pkg::HANDLE_W-1:0] slot_obj [SLOTS];
   logic [dtr_pkg::RIGHTS_W-1:0] slot_base [SLOTS];
   logic [dtr_pkg::RIGHTS_W-1:0] slot_inherit [SLOTS];

   // occupancy as seen by the stimulus generator, to aim lookups and closes
   logic [SLOTS-1:0]             gen_used = '0;
   logic [dtr_pkg::RIGHTS_W-1:0] gen_base [SLOTS];

   int total_items  = 0;
   int items_done   = 0;
   int failures     = 0;
   int mismatches   = 0;
   int cycle_count  = 0;
   int gap_left     = 0;
   int n_add        = 0;
   int n_lookup     = 0;
   int n_close      = 0;
   int n_unused     = 0;
   int n_full       = 0;
   int n_norights   = 0;
   int n_found      = 0;

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         slot_live[i] = 1'b0;
         slot_obj[i] = '0;
         slot_base[i] = '0;
         slot_inherit[i] = '0;
         gen_base[i] = '0;
      end
   end

   function automatic logic [dtr_pkg::RIGHTS_W-1:0] rand_mask();
      return {$urandom, $urandom};
   endfunction

   function automatic desc_rsp_type table_outcome(desc_req_type r);
      desc_rsp_type o;
      int           s;
      o = '0;
      o.status = dtr_pkg::STS_BADDESC;
      o.slot = r.slot;
      case (r.kind)
         dtr_pkg::REQ_ADD: begin
            n_add++;
            s = 0;
            while (s < SLOTS && slot_live[s]) s++;
            if (s >= SLOTS) begin
               o.status = dtr_pkg::STS_FULL;
               o.slot = '0;
               n_full++;
            end else begin
               slot_live[s] = 1'b1;
               slot_obj[s] = r.handle;
               slot_base[s] = r.base;
               slot_inherit[s] = r.inherit;
               o.status = dtr_pkg::STS_OK;
               o.slot = dtr_pkg::SLOT_W'(s);
            end
         end
         dtr_pkg::REQ_LOOKUP: begin
            n_lookup++;
            if (slot_live[r.slot]) begin
               if ((slot_base[r.slot] & r.need) != r.need) begin
                  o.status = dtr_pkg::STS_NORIGHTS;
                  n_norights++;
               end else begin
                  o.status = dtr_pkg::STS_OK;
                  o.handle = slot_obj[r.slot];
                  o.base = slot_base[r.slot];
                  o.inherit = slot_inherit[r.slot];
                  n_found++;
               end
            end
         end
         dtr_pkg::REQ_CLOSE: begin
            n_close++;
            if (slot_live[r.slot]) begin
               slot_live[r.slot] = 1'b0;
               o.status = dtr_pkg::STS_OK;
            end
         end
         default: n_unused++;
      endcase
      return o;
   endfunction

   task automatic queue_request(input logic [1:0] kind, input int slot,
                                input logic [dtr_pkg::HANDLE_W-1:0] handle,
                                input logic [dtr_pkg::RIGHTS_W-1:0] base,
                                input logic [dtr_pkg::RIGHTS_W-1:0] inherit,
                                input logic [dtr_pkg::RIGHTS_W-1:0] need);
      desc_req_type r;
      int           s;
      r.kind = kind;
      r.slot = dtr_pkg::SLOT_W'(slot);
      r.handle = handle;
      r.base = base;
      r.inherit = inherit;
      r.need = need;
      request_backlog.push_back(r);
      if (kind == dtr_pkg::REQ_ADD) begin
         s = 0;
         while (s < SLOTS && gen_used[s]) s++;
         if (s < SLOTS) begin
            gen_used[s] = 1'b1;
            gen_base[s] = base;
         end
      end else if (kind == dtr_pkg::REQ_CLOSE) begin
         gen_used[r.slot] = 1'b0;
      end
   endtask

   function automatic int pick_used();
      int s;
      s = $urandom_range(0, SLOTS-1);
      for (int k = 0; k < SLOTS; k++) begin
         if (gen_used[(s + k) % SLOTS]) return (s + k) % SLOTS;
      end
      return s;
   endfunction

   task automatic random_request(input int add_pct, input int close_pct);
      int                           roll;
      int                           slot;
      logic [dtr_pkg::RIGHTS_W-1:0] base;
      logic [dtr_pkg::RIGHTS_W-1:0] need;
      roll = $urandom_range(0, 99);
      slot = ($urandom_range(0, 99) < 85) ? pick_used()
                                          : $urandom_range(0, SLOTS-1);
      case ($urandom_range(0, 9))
         0:       base = '0;
         1:       base = '1;
         default: base = rand_mask();
      endcase
      case ($urandom_range(0, 9))
         0, 1:       need = '0;
         2, 3, 4, 5: need = gen_base[slot] & rand_mask();
         6, 7:       need = (gen_base[slot] & rand_mask()) |
                            (64'd1 << $urandom_range(0, 63));
         default:    need = rand_mask();
      endcase
      if (roll < 3)
         queue_request(REQ_UNUSED, slot, $urandom, base, rand_mask(), need);
      else if (roll < 3 + add_pct)
         queue_request(dtr_pkg::REQ_ADD, $urandom_range(0, SLOTS-1), $urandom, base,
                       rand_mask(), rand_mask());
      else if (roll < 3 + add_pct + close_pct)
         queue_request(dtr_pkg::REQ_CLOSE, slot, $urandom, base, rand_mask(), need);
      else
         queue_request(dtr_pkg::REQ_LOOKUP, slot, $urandom, base, rand_mask(), need);
   endtask

   // driver: one transfer per accepted start, bursts of idle cycles until the tail
   always @(posedge clock) begin : drive
      logic         sent;
      desc_req_type cur;
      sent = start && !busy;
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else begin
         if (sent) begin
            cur = request_backlog.pop_front();
            outstanding_replies.push_back(table_outcome(cur));
            items_done++;
         end
         if (start && !sent) begin
            // held until the block takes it
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (request_backlog.size() == 0) begin
            start <= 1'b0;
         end else if (items_done < total_items - CALM_TAIL &&
                      $urandom_range(0, 5) == 0) begin
            gap_left <= $urandom_range(0, 13);
            start <= 1'b0;
         end else begin
            cur = request_backlog[0];
            start <= 1'b1;
            req_type <= cur.kind;
            req_slot_num <= cur.slot;
            req_object_handle <= cur.handle;
            req_base_rights <= cur.base;
            req_inherit_rights <= cur.inherit;
            req_required_rights <= cur.need;
         end
      end
   end

   // monitor: every strobe is one result transfer
   always @(posedge clock) begin : watch
      desc_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (outstanding_replies.size() == 0) begin
            failures++;
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected result: status %0d slot %0d", rsp_status, rsp_slot_out);
         end else begin
            want = outstanding_replies.pop_front();
            if (rsp_status !== want.status || rsp_slot_out !== want.slot ||
                rsp_handle_out !== want.handle || rsp_base_rights_out !== want.base ||
                rsp_inherit_rights_out !== want.inherit) begin
               failures++;
               mismatches++;
               if (mismatches <= REPORT_MAX) begin
                  $display("mismatch: exp sts %0d slot %0d h %h b %h i %h",
                           want.status, want.slot, want.handle, want.base, want.inherit);
                  $display("          got sts %0d slot %0d h %h b %h i %h",
                           rsp_status, rsp_slot_out, rsp_handle_out,
                           rsp_base_rights_out, rsp_inherit_rights_out);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, outstanding_replies.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin : stimulus
      int n_rand;
      n_rand = 0;

      // empty table, fills of extreme values, rights checks, close and reuse
      queue_request(dtr_pkg::REQ_LOOKUP, 0, '0, '0, '0, '0);
      queue_request(dtr_pkg::REQ_CLOSE, SLOTS-1, '0, '0, '0, '0);
      queue_request(dtr_pkg::REQ_ADD, 0, '0, '0, '0, '0);
      queue_request(dtr_pkg::REQ_ADD, SLOTS-1, '1, '1, '1, '1);
      queue_request(dtr_pkg::REQ_ADD, 0, $urandom, {16{4'h5}}, {16{4'hA}}, '0);
      queue_request(dtr_pkg::REQ_LOOKUP, 0, '0, '0, '0, '0);
      queue_request(dtr_pkg::REQ_LOOKUP, 0, '0, '0, '0, 64'd1);
      queue_request(dtr_pkg::REQ_LOOKUP, 1, '0, '0, '0, '1);
      queue_request(dtr_pkg::REQ_LOOKUP, 2, '0, '0, '0, {16{4'h5}});
      queue_request(dtr_pkg::REQ_LOOKUP, 2, '0, '0, '0, 64'h8000_0000_0000_0000);
      queue_request(dtr_pkg::REQ_LOOKUP, 2, '1, '1, '1, '1);
      queue_request(dtr_pkg::REQ_CLOSE, 1, '0, '0, '0, '0);
      queue_request(dtr_pkg::REQ_LOOKUP, 1, '0, '0, '0, '0);
      queue_request(dtr_pkg::REQ_CLOSE, 1, '0, '0, '0, '0);
      queue_request(dtr_pkg::REQ_ADD, 5, $urandom, rand_mask(), rand_mask(), rand_mask());
      queue_request(REQ_UNUSED, SLOTS-1, '1, '1, '1, '1);
      queue_request(REQ_UNUSED, 0, $urandom, rand_mask(), rand_mask(), '0);
      queue_request(dtr_pkg::REQ_LOOKUP, SLOTS-1, '0, '0, '0, '0);
      queue_request(dtr_pkg::REQ_CLOSE, 0, '0, '0, '0, '0);
      queue_request(dtr_pkg::REQ_CLOSE, 2, '0, '0, '0, '0);
      queue_request(dtr_pkg::REQ_CLOSE, 1, '0, '0, '0, '0);

      // mixed traffic, then fill to capacity, adds while full, mixed, drain, mixed again
      repeat (100) begin
         random_request(40, 20);
         n_rand++;
      end
      while (!(&gen_used)) begin
         random_request(90, 0);
         n_rand++;
      end
      repeat (8) begin
         queue_request(dtr_pkg::REQ_ADD, $urandom_range(0, SLOTS-1), $urandom, rand_mask(),
                       rand_mask(), rand_mask());
         n_rand++;
      end
      repeat (40) begin
         random_request(45, 25);
         n_rand++;
      end
      repeat (130) begin
         random_request(10, 60);
         n_rand++;
      end
      while (n_rand < RANDOM_ITEMS) begin
         random_request(35, 30);
         n_rand++;
      end
      total_items = request_backlog.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (items_done < total_items) @(posedge clock);
      while (outstanding_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests: %0d add (%0d refused full), %0d lookup, %0d close, %0d unused",
               total_items, n_add, n_full, n_lookup, n_close, n_unused);
      $display("lookups: %0d found, %0d refused for rights; %0d mismatches",
               n_found, n_norights, mismatches);
      if (failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

[filelist.f]
+incdir+design
design/dtr_pkg.sv
design/dtr_ctrl.sv
design/dtr_dpath.sv
design/descriptor_table_with_rights.sv
tb/sv/tb_descriptor_table_with_rights.sv
